// ----- hdl/rds_pkg.sv -----
package rds_pkg;

  localparam int TEXT_LEN = 64;
  localparam int NAME_LEN = 8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [5:0] TAG_TITLE  = 6'd1;
  localparam logic [5:0] TAG_ARTIST = 6'd4;

  localparam logic [3:0] GT_NAME = 4'd0;
  localparam logic [3:0] GT_TEXT = 4'd2;
  localparam logic [3:0] GT_ODA  = 4'd3;

  localparam logic [1:0] SEL_NAME   = 2'd0;
  localparam logic [1:0] SEL_TEXT   = 2'd1;
  localparam logic [1:0] SEL_TITLE  = 2'd2;
  localparam logic [1:0] SEL_ARTIST = 2'd3;

  localparam logic CFG_APP_ID  = 1'b0;
  localparam logic CFG_MAX_ERR = 1'b1;

  typedef struct packed {
    logic        mode;
    logic        fifo_used;
    logic        sync;
    logic        ok_a;
    logic        ok_b;
    logic        ok_c;
    logic        ok_d;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic [7:0]  read_address;
  } item_t;

  typedef struct packed {
    logic [15:0] prog_id;
    logic [4:0]  prog_type;
    logic        sync_flag;
    logic [3:0]  name_segments;
    logic [15:0] text_segments;
    logic        name_complete;
    logic        name_partial;
    logic        text_visible;
    logic        title_visible;
    logic        artist_visible;
    logic [7:0]  read_char;
  } result_t;

  function automatic logic is_visible(input logic [7:0] ch);
    return (ch > CH_SPACE) && (ch < CH_DEL);
  endfunction

  function automatic logic is_trim(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_CR) || (ch == CH_LF);
  endfunction

endpackage

// ----- hdl/rds_group_decoder_top.sv -----
// A character read and a rejected group skip the store walks. An accepted
// group takes one walk of the 64-entry stores; a RadioText group adds a walk
// for the carriage return, and each RT+ span a check walk and a copy walk.
// The single-port text memory walks set the length of the work; one item
// is worked on at a time, with a two-word input queue and one result register.
// Reset is synchronous; all text stores read as empty right after it.
module rds_group_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic        fifo_used,
  input  logic        sync,
  input  logic [1:0]  err_a,
  input  logic [1:0]  err_b,
  input  logic [1:0]  err_c,
  input  logic [1:0]  err_d,
  input  logic [15:0] word_a,
  input  logic [15:0] word_b,
  input  logic [15:0] word_c,
  input  logic [15:0] word_d,
  input  logic [7:0]  read_address,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] prog_id,
  output logic [4:0]  prog_type,
  output logic        sync_flag,
  output logic [3:0]  name_segments,
  output logic [15:0] text_segments,
  output logic        name_complete,
  output logic        name_partial,
  output logic        text_visible,
  output logic        title_visible,
  output logic        artist_visible,
  output logic [7:0]  read_char,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data
);
  import rds_pkg::*;

  logic [15:0] app_id;
  logic [1:0]  max_level;
  item_t       item;
  logic        item_valid;
  logic        item_take;
  result_t     res;
  logic        res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      app_id    <= 16'h4BD7;
      max_level <= 2'd2;
    end else if (wr_en) begin
      case (wr_index)
        CFG_APP_ID:  app_id <= wr_data;
        CFG_MAX_ERR: max_level <= wr_data[1:0];
        default:     app_id <= app_id;
      endcase
    end
  end

  rds_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .fifo_used    (fifo_used),
    .sync         (sync),
    .err_a        (err_a),
    .err_b        (err_b),
    .err_c        (err_c),
    .err_d        (err_d),
    .word_a       (word_a),
    .word_b       (word_b),
    .word_c       (word_c),
    .word_d       (word_d),
    .read_address (read_address),
    .max_level    (max_level),
    .item         (item),
    .item_valid   (item_valid),
    .item_take    (item_take)
  );

  rds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .app_id     (app_id),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .res        (res),
    .res_valid  (res_valid),
    .res_pop    (pop)
  );

  assign empty          = !res_valid;
  assign prog_id        = res.prog_id;
  assign prog_type      = res.prog_type;
  assign sync_flag      = res.sync_flag;
  assign name_segments  = res.name_segments;
  assign text_segments  = res.text_segments;
  assign name_complete  = res.name_complete;
  assign name_partial   = res.name_partial;
  assign text_visible   = res.text_visible;
  assign title_visible  = res.title_visible;
  assign artist_visible = res.artist_visible;
  assign read_char      = res.read_char;

  a_complete_partial: assert property (@(posedge clk) disable iff (rst)
    !empty && name_complete |-> name_partial)
    else $error("complete station name without the partial flag");

  a_complete_mask: assert property (@(posedge clk) disable iff (rst)
    !empty && name_complete |-> name_segments == 4'hF)
    else $error("complete station name with segments missing");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result word present right after reset");

endmodule

// ----- hdl/rds_front.sv -----
module rds_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              mode,
  input  logic              fifo_used,
  input  logic              sync,
  input  logic [1:0]        err_a,
  input  logic [1:0]        err_b,
  input  logic [1:0]        err_c,
  input  logic [1:0]        err_d,
  input  logic [15:0]       word_a,
  input  logic [15:0]       word_b,
  input  logic [15:0]       word_c,
  input  logic [15:0]       word_d,
  input  logic [7:0]        read_address,
  input  logic [1:0]        max_level,
  output rds_pkg::item_t    item,
  output logic              item_valid,
  input  logic              item_take
);
  import rds_pkg::*;

  item_t      q [2];
  item_t      incoming;
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  // Block usability is settled here so the back end sees only flags.
  always_comb begin
    incoming.mode         = mode;
    incoming.fifo_used    = fifo_used;
    incoming.sync         = sync;
    incoming.ok_a         = err_a <= max_level;
    incoming.ok_b         = err_b <= max_level;
    incoming.ok_c         = err_c <= max_level;
    incoming.ok_d         = err_d <= max_level;
    incoming.word_a       = word_a;
    incoming.word_b       = word_b;
    incoming.word_c       = word_c;
    incoming.word_d       = word_d;
    incoming.read_address = read_address;
  end

  assign full       = count == 2'd2;
  assign item_valid = count != 2'd0;
  assign item       = q[rp];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q[wp] <= incoming;
  end

endmodule

// ----- hdl/rds_back.sv -----
module rds_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       app_id,
  input  rds_pkg::item_t    item,
  input  logic              item_valid,
  output logic              item_take,
  output rds_pkg::result_t  res,
  output logic              res_valid,
  input  logic              res_pop
);
  import rds_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_HEAD  = 11'b00000000010,
    S_WRITE = 11'b00000000100,
    S_CR    = 11'b00000001000,
    S_TAG   = 11'b00000010000,
    S_SPAN  = 11'b00000100000,
    S_COPY  = 11'b00001000000,
    S_VIS   = 11'b00010000000,
    S_READ  = 11'b00100000000,
    S_RCAP  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state;
  item_t  cur;

  logic [15:0] pi;
  logic [4:0]  pty;
  logic        sync_st;
  logic [7:0]  station [NAME_LEN];
  logic [3:0]  st_mask;
  logic [15:0] tx_mask;
  logic        ab_flag;
  logic        ver_b;
  logic [4:0]  tg_code;
  logic        tg_known;
  logic        tog_seen;
  logic        tog;
  logic        running;
  logic [5:0]  tg_type  [2];
  logic [5:0]  tg_start [2];
  logic [5:0]  tg_len   [2];

  logic [7:0] text_mem   [TEXT_LEN];
  logic [7:0] title_mem  [TEXT_LEN];
  logic [7:0] artist_mem [TEXT_LEN];
  logic [TEXT_LEN-1:0] text_vld;
  logic [TEXT_LEN-1:0] title_vld;
  logic [TEXT_LEN-1:0] artist_vld;

  logic [5:0] raddr;
  logic [7:0] text_q, title_q, artist_q;
  logic       text_vq, title_vq, artist_vq;
  logic [7:0] text_ch, title_ch, artist_ch;

  logic [6:0] cnt;
  logic [6:0] limit;
  logic       issue;
  logic       scan;
  logic       dv;
  logic [5:0] didx;
  logic [1:0] cw;
  logic [1:0] kc;
  logic       k;
  logic [5:0] last;
  logic       have;
  logic       stop_t, stop_ti, stop_ar;
  logic       acc_t, acc_ti, acc_ar;
  logic       acc_t_n, acc_ti_n, acc_ar_n;
  logic       vis_text, vis_title, vis_artist;
  logic [7:0] rchar;

  logic [3:0]  gtype;
  logic        vb;
  logic        ab;
  logic        pi_chg;
  logic [15:0] eff_tx_mask;
  logic [3:0]  eff_st_mask;
  logic        eff_ab, eff_vb, eff_known, eff_seen, eff_tog;
  logic [4:0]  eff_code;

  logic [6:0] span_len;
  logic [6:0] span_end;
  logic       span_bad;
  logic       tag_rel;
  logic       to_title;

  logic       text_we;
  logic [5:0] text_waddr;
  logic [7:0] text_wdata;
  logic       last_write;
  logic       title_we;
  logic       artist_we;

  logic       name_vis;
  logic       name_stop;
  result_t    res_next;
  logic [5:0] ridx;

  assign gtype  = cur.word_b[15:12];
  assign vb     = cur.word_b[11];
  assign ab     = cur.word_b[4];
  assign pi_chg = (pi != 16'd0) && (pi != cur.word_a);
  assign ridx   = cur.read_address[5:0];

  // A programme change wipes everything, so decisions in the header cycle
  // look at the state as it stands after that wipe.
  assign eff_tx_mask = pi_chg ? 16'd0 : tx_mask;
  assign eff_st_mask = pi_chg ? 4'd0 : st_mask;
  assign eff_ab      = pi_chg ? 1'b0 : ab_flag;
  assign eff_vb      = pi_chg ? 1'b0 : ver_b;
  assign eff_known   = pi_chg ? 1'b0 : tg_known;
  assign eff_seen    = pi_chg ? 1'b0 : tog_seen;
  assign eff_tog     = pi_chg ? 1'b0 : tog;
  assign eff_code    = pi_chg ? 5'd0 : tg_code;

  assign k        = kc[0];
  assign span_len = {1'b0, tg_len[k]} + 7'd1;
  assign span_end = {1'b0, tg_start[k]} + span_len;
  assign span_bad = span_end > 7'(TEXT_LEN);
  assign tag_rel  = (tg_type[k] == TAG_TITLE) || (tg_type[k] == TAG_ARTIST);
  assign to_title = tg_type[k] == TAG_TITLE;

  assign text_ch   = text_vq ? text_q : CH_NUL;
  assign title_ch  = title_vq ? title_q : CH_NUL;
  assign artist_ch = artist_vq ? artist_q : CH_NUL;

  assign item_take = (state == S_IDLE) && item_valid;

  always_comb begin
    case (state)
      S_SPAN, S_COPY: raddr = tg_start[k] + cnt[5:0];
      S_READ:         raddr = ridx;
      default:        raddr = cnt[5:0];
    endcase
  end

  always_comb begin
    case (state)
      S_CR, S_VIS: limit = 7'(TEXT_LEN);
      S_SPAN:      limit = span_len;
      S_COPY:      limit = {1'b0, last} + 7'd1;
      default:     limit = 7'd0;
    endcase
    issue = cnt < limit;
    scan  = (state == S_CR) || (state == S_SPAN) || (state == S_COPY) || (state == S_VIS);
  end

  // Version A carries four characters in blocks C and D, version B two in D.
  always_comb begin
    text_we = state == S_WRITE;
    if (vb) begin
      text_waddr = {1'b0, cur.word_b[3:0], cw[0]};
      text_wdata = cw[0] ? cur.word_d[7:0] : cur.word_d[15:8];
      last_write = cw[0];
    end else begin
      text_waddr = {cur.word_b[3:0], cw};
      case (cw)
        2'd0:    text_wdata = cur.word_c[15:8];
        2'd1:    text_wdata = cur.word_c[7:0];
        2'd2:    text_wdata = cur.word_d[15:8];
        default: text_wdata = cur.word_d[7:0];
      endcase
      last_write = cw == 2'd3;
    end
  end

  assign title_we  = (state == S_COPY) && dv && to_title;
  assign artist_we = (state == S_COPY) && dv && !to_title;

  assign acc_t_n  = acc_t  || (!stop_t  && is_visible(text_ch));
  assign acc_ti_n = acc_ti || (!stop_ti && is_visible(title_ch));
  assign acc_ar_n = acc_ar || (!stop_ar && is_visible(artist_ch));

  always_comb begin
    name_vis  = 1'b0;
    name_stop = 1'b0;
    for (int i = 0; i < NAME_LEN; i++) begin
      if (!name_stop) begin
        if (station[i] == CH_NUL) name_stop = 1'b1;
        else if (is_visible(station[i])) name_vis = 1'b1;
      end
    end
  end

  always_comb begin
    res_next.prog_id        = pi;
    res_next.prog_type      = pty;
    res_next.sync_flag      = sync_st;
    res_next.name_segments  = st_mask;
    res_next.text_segments  = tx_mask;
    res_next.name_complete  = (st_mask == 4'hF) && name_vis;
    res_next.name_partial   = st_mask[0] && name_vis;
    res_next.text_visible   = vis_text;
    res_next.title_visible  = vis_title;
    res_next.artist_visible = vis_artist;
    res_next.read_char      = rchar;
  end

  always_ff @(posedge clk) begin
    if (text_we) text_mem[text_waddr] <= text_wdata;
    if (title_we) title_mem[didx] <= text_ch;
    if (artist_we) artist_mem[didx] <= text_ch;
    text_q    <= text_mem[raddr];
    title_q   <= title_mem[raddr];
    artist_q  <= artist_mem[raddr];
    text_vq   <= text_vld[raddr];
    title_vq  <= title_vld[raddr];
    artist_vq <= artist_vld[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      pi         <= 16'd0;
      pty        <= 5'd0;
      sync_st    <= 1'b0;
      for (int i = 0; i < NAME_LEN; i++) station[i] <= CH_SPACE;
      st_mask    <= 4'd0;
      tx_mask    <= 16'd0;
      ab_flag    <= 1'b0;
      ver_b      <= 1'b0;
      tg_code    <= 5'd0;
      tg_known   <= 1'b0;
      tog_seen   <= 1'b0;
      tog        <= 1'b0;
      running    <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        tg_type[i]  <= 6'd0;
        tg_start[i] <= 6'd0;
        tg_len[i]   <= 6'd0;
      end
      text_vld   <= '0;
      title_vld  <= '0;
      artist_vld <= '0;
      vis_text   <= 1'b0;
      vis_title  <= 1'b0;
      vis_artist <= 1'b0;
      cnt        <= 7'd0;
      dv         <= 1'b0;
      cw         <= 2'd0;
      kc         <= 2'd0;
      have       <= 1'b0;
      stop_t     <= 1'b0;
      stop_ti    <= 1'b0;
      stop_ar    <= 1'b0;
      acc_t      <= 1'b0;
      acc_ti     <= 1'b0;
      acc_ar     <= 1'b0;
    end else begin
      cnt  <= scan ? cnt + {6'd0, issue} : 7'd0;
      dv   <= issue;
      didx <= cnt[5:0];
      if (res_pop) res_valid <= 1'b0;
      if (state != S_VIS) begin
        stop_t  <= 1'b0;
        stop_ti <= 1'b0;
        stop_ar <= 1'b0;
        acc_t   <= 1'b0;
        acc_ti  <= 1'b0;
        acc_ar  <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            state <= S_HEAD;
          end
        end

        S_HEAD: begin
          if (cur.mode) begin
            state <= S_READ;
          end else begin
            sync_st <= cur.sync;
            rchar   <= 8'd0;
            if (!cur.fifo_used || !cur.sync || !cur.ok_a || !cur.ok_b) begin
              state <= S_DONE;
            end else begin
              if (pi_chg) begin
                for (int i = 0; i < NAME_LEN; i++) station[i] <= CH_SPACE;
                st_mask    <= 4'd0;
                tx_mask    <= 16'd0;
                ab_flag    <= 1'b0;
                ver_b      <= 1'b0;
                tg_code    <= 5'd0;
                tg_known   <= 1'b0;
                tog_seen   <= 1'b0;
                tog        <= 1'b0;
                running    <= 1'b0;
                for (int i = 0; i < 2; i++) begin
                  tg_type[i]  <= 6'd0;
                  tg_start[i] <= 6'd0;
                  tg_len[i]   <= 6'd0;
                end
                text_vld   <= '0;
                title_vld  <= '0;
                artist_vld <= '0;
              end
              pi    <= cur.word_a;
              pty   <= cur.word_b[9:5];
              state <= S_VIS;
              if (gtype == GT_ODA && !vb && cur.ok_d && cur.word_d == app_id) begin
                tg_code  <= cur.word_b[4:0];
                tg_known <= 1'b1;
              end else if (gtype == GT_NAME && cur.ok_d) begin
                station[{cur.word_b[1:0], 1'b0}] <= cur.word_d[15:8];
                station[{cur.word_b[1:0], 1'b1}] <= cur.word_d[7:0];
                st_mask <= eff_st_mask | (4'd1 << cur.word_b[1:0]);
              end else if (gtype == GT_TEXT) begin
                if (cur.ok_d && (vb || cur.ok_c)) begin
                  // A flip of the A/B flag or of the version starts a new text.
                  if (eff_tx_mask != 16'd0 && (ab != eff_ab || vb != eff_vb)) begin
                    text_vld   <= '0;
                    title_vld  <= '0;
                    artist_vld <= '0;
                    tx_mask    <= 16'd1 << cur.word_b[3:0];
                  end else begin
                    tx_mask <= eff_tx_mask | (16'd1 << cur.word_b[3:0]);
                  end
                  ab_flag <= ab;
                  ver_b   <= vb;
                  if (vb) text_vld[TEXT_LEN/2] <= 1'b0;
                  cw    <= 2'd0;
                  state <= S_WRITE;
                end
              end else if (eff_known && {gtype, vb} == eff_code && !vb &&
                           cur.ok_c && cur.ok_d) begin
                if (!eff_seen || cur.word_b[4] != eff_tog || !cur.word_b[3]) begin
                  title_vld  <= '0;
                  artist_vld <= '0;
                end
                tog_seen    <= 1'b1;
                tog         <= cur.word_b[4];
                running     <= cur.word_b[3];
                tg_type[0]  <= {cur.word_b[2:0], cur.word_c[15:13]};
                tg_start[0] <= cur.word_c[12:7];
                tg_len[0]   <= cur.word_c[6:1];
                tg_type[1]  <= {cur.word_c[0], cur.word_d[15:11]};
                tg_start[1] <= cur.word_d[10:5];
                tg_len[1]   <= {1'b0, cur.word_d[4:0]};
                kc          <= 2'd0;
                state       <= S_TAG;
              end
            end
          end
        end

        S_WRITE: begin
          text_vld[text_waddr] <= 1'b1;
          cw <= cw + 2'd1;
          if (last_write) state <= S_CR;
        end

        // Only the first carriage return counts; it becomes the end of text.
        S_CR: begin
          if (dv) begin
            if (text_ch == CH_CR) begin
              text_vld[didx] <= 1'b0;
              kc    <= 2'd0;
              state <= S_TAG;
            end else if (didx == 6'(TEXT_LEN - 1)) begin
              kc    <= 2'd0;
              state <= S_TAG;
            end
          end
        end

        S_TAG: begin
          if (!(tg_known && running) || kc[1]) begin
            state <= S_VIS;
          end else if (tag_rel && !span_bad) begin
            have  <= 1'b0;
            state <= S_SPAN;
          end else begin
            kc <= kc + 2'd1;
          end
        end

        // Walk the span: any NUL rejects it, and the last non-blank
        // character sets the trimmed length.
        S_SPAN: begin
          if (dv) begin
            if (text_ch == CH_NUL) begin
              kc    <= kc + 2'd1;
              state <= S_TAG;
            end else begin
              if (!is_trim(text_ch)) begin
                last <= didx;
                have <= 1'b1;
              end
              if ({1'b0, didx} == span_len - 7'd1) begin
                if (have || !is_trim(text_ch)) begin
                  cnt   <= 7'd0;
                  dv    <= 1'b0;
                  state <= S_COPY;
                  if (to_title) title_vld <= '0;
                  else artist_vld <= '0;
                end else begin
                  kc    <= kc + 2'd1;
                  state <= S_TAG;
                end
              end
            end
          end
        end

        S_COPY: begin
          if (dv) begin
            if (to_title) title_vld[didx] <= 1'b1;
            else artist_vld[didx] <= 1'b1;
            if (didx == last) begin
              kc    <= kc + 2'd1;
              state <= S_TAG;
            end
          end
        end

        S_VIS: begin
          if (dv) begin
            stop_t  <= stop_t  || (text_ch == CH_NUL);
            stop_ti <= stop_ti || (title_ch == CH_NUL);
            stop_ar <= stop_ar || (artist_ch == CH_NUL);
            acc_t   <= acc_t_n;
            acc_ti  <= acc_ti_n;
            acc_ar  <= acc_ar_n;
            if (didx == 6'(TEXT_LEN - 1)) begin
              vis_text   <= acc_t_n;
              vis_title  <= acc_ti_n;
              vis_artist <= acc_ar_n;
              state      <= S_DONE;
            end
          end
        end

        S_READ: begin
          state <= S_RCAP;
        end

        S_RCAP: begin
          case (cur.read_address[7:6])
            SEL_NAME:   rchar <= (ridx < 6'(NAME_LEN)) ? station[ridx[2:0]] : 8'd0;
            SEL_TEXT:   rchar <= text_ch;
            SEL_TITLE:  rchar <= title_ch;
            SEL_ARTIST: rchar <= artist_ch;
            default:    rchar <= 8'd0;
          endcase
          state <= S_DONE;
        end

        S_DONE: begin
          if (!res_valid || res_pop) begin
            res       <= res_next;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
